// ----- rtl/b64sd_pkg.sv -----
`timescale 1ns / 1ps

package b64sd_pkg;

  // Largest number of bytes one string may decode to.
  localparam int CAPACITY = 512;

  localparam logic [9:0] COUNT_MAX = 10'h3FF;

  // Codes out of the character map beside the six-bit alphabet values.
  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd65;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  held;
    logic [9:0]  count;
    logic        stopped;
    status_t     err;
  } dec_state_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic        finished;
    status_t     status;
    logic [9:0]  byte_count;
  } dec_result_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    if (c >= "A" && c <= "Z") begin
      v = 7'(c - 8'd65);
    end else if (c >= "a" && c <= "z") begin
      v = 7'(c - 8'd97 + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      v = 7'(c - 8'd48 + 8'd52);
    end else if (c == "+") begin
      v = 7'd62;
    end else if (c == "/") begin
      v = 7'd63;
    end else if (c == "=") begin
      v = SEXTET_PAD;
    end else begin
      v = SEXTET_BAD;
    end
    return v;
  endfunction

endpackage

// ----- rtl/base64_stream_decoder.sv -----
`timescale 1ns / 1ps

// Base64 stream decoder.
// in_*  : one character per item, in_tdata[7:0] = character, in_tlast = end of
//         string (character ignored on that item).
// out_* : exactly one result per input item. out_tuser = a decoded byte is
//         present in out_tdata[7:0]; out_tlast = end item, status and count are
//         final. out_tdata[9:8] = status (0 ok, 1 bad character, 2 over
//         capacity), out_tdata[19:10] = bytes decoded so far.
// The character map, accumulator shift and capacity compare are combinational
// and sit between the decoder state and the result register. Throughput is
// one item per cycle while the output is not stalled; a new item is taken
// while the previous result is taken in the same cycle.
// When out_tready is low with a result held, in_tready drops and the result
// and decoder state hold until it is taken.
// Reset (rst_n low, synchronous) clears the decoder state and drops
// out_tvalid; an end item also clears the state after reporting.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [9:8] status, [19:10] byte_count
  output logic        out_tlast,
  output logic        out_tuser   // [0] byte_valid
);

  b64sd_pkg::dec_state_t  st_r;
  b64sd_pkg::dec_state_t  st_nxt;
  b64sd_pkg::dec_result_t res_nxt;
  b64sd_pkg::dec_result_t res_r;
  logic                   out_valid_r;
  logic                   in_fire;

  b64sd_step u_step (
    .st_i     (st_r),
    .ch_i     (in_tdata),
    .is_end_i (in_tlast),
    .st_o     (st_nxt),
    .res_o    (res_nxt)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.byte_count, res_r.status, res_r.data_byte};
  assign out_tlast  = res_r.finished;
  assign out_tuser  = res_r.byte_valid;

`ifndef SYNTHESIS
  // An end item never carries a decoded byte.
  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser)
    else $error("end item carries a byte");

  // Bytes come out only while no error is latched.
  a_byte_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> res_r.status == b64sd_pkg::STATUS_OK)
    else $error("byte emitted with error status");

  // The end item clears the whole decoder state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> st_r == '0)
    else $error("state not cleared after end item");

  // A latched error holds until the end item.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.err != b64sd_pkg::STATUS_OK && !(in_fire && in_tlast) |=> $stable(st_r.err))
    else $error("error code changed before end item");

  // The byte count advances by at most one per item.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tlast |=> st_r.count == $past(st_r.count)
                             || st_r.count == $past(st_r.count) + 10'd1)
    else $error("byte count jumped");
`endif

endmodule

// ----- rtl/b64sd_step.sv -----
`timescale 1ns / 1ps

module b64sd_step (
  input  b64sd_pkg::dec_state_t  st_i,
  input  logic [7:0]             ch_i,
  input  logic                   is_end_i,
  output b64sd_pkg::dec_state_t  st_o,
  output b64sd_pkg::dec_result_t res_o
);

  logic [6:0]  sextet;
  logic [11:0] acc_shift;
  logic [3:0]  held_add;
  logic [3:0]  held_left;
  logic        is_ws;

  assign sextet    = b64sd_pkg::sextet_of(ch_i);
  assign acc_shift = {st_i.acc[5:0], sextet[5:0]};
  assign held_add  = st_i.held + 4'd6;
  assign held_left = held_add - 4'd8;
  assign is_ws     = (ch_i == b64sd_pkg::CH_SPACE) || (ch_i == b64sd_pkg::CH_CR)
                     || (ch_i == b64sd_pkg::CH_LF);

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    if (is_end_i) begin
      res_o.finished   = 1'b1;
      res_o.status     = st_i.err;
      res_o.byte_count = st_i.count;
      st_o             = '0;
    end else begin
      if (!st_i.stopped && st_i.err == b64sd_pkg::STATUS_OK) begin
        if (sextet == b64sd_pkg::SEXTET_BAD) begin
          if (!is_ws) begin
            st_o.err = b64sd_pkg::STATUS_BAD_CHAR;
          end
        end else if (sextet == b64sd_pkg::SEXTET_PAD) begin
          st_o.stopped = 1'b1;
        end else begin
          st_o.acc  = acc_shift;
          st_o.held = held_add;
          if (held_add >= 4'd8) begin
            st_o.held = held_left;
            if (32'(st_i.count) >= b64sd_pkg::CAPACITY) begin
              st_o.err = b64sd_pkg::STATUS_OVERFLOW;
            end else begin
              res_o.data_byte  = 8'(acc_shift >> held_left);
              res_o.byte_valid = 1'b1;
              if (st_i.count != b64sd_pkg::COUNT_MAX) begin
                st_o.count = st_i.count + 10'd1;
              end
            end
          end
        end
      end
      res_o.status     = st_o.err;
      res_o.byte_count = st_o.count;
    end
  end

endmodule
